// ===== rtl/weighted_layer_cache_eviction_assert.svh =====
// Assertion macros for the layer cache block
`ifndef WEIGHTED_LAYER_CACHE_EVICTION_ASSERT_SVH
`define WEIGHTED_LAYER_CACHE_EVICTION_ASSERT_SVH
`ifndef SYNTHESIS
`define WLCE_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wlce: implication check failed");
`define WLCE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wlce: next-cycle check failed");
`else
`define WLCE_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define WLCE_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/wlce_pkg.sv =====
// Shared types and constants for the layer cache block
`timescale 1ns / 1ps
`default_nettype none
package wlce_pkg;

    typedef enum logic [2:0] {
        CMD_DEFINE   = 3'd0,
        CMD_REQUEST  = 3'd1,
        CMD_RELEASE  = 3'd2,
        CMD_SETPRIO  = 3'd3,
        CMD_RSTPRIO  = 3'd4,
        CMD_PREFETCH = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_LOADED    = 3'd1,
        ST_NO_SPACE  = 3'd2,
        ST_BAD_INDEX = 3'd3,
        ST_DONE      = 3'd4
    } t_status;

    typedef struct packed {
        logic        cached;
        logic [31:0] last;
        logic [15:0] count;
        logic [15:0] prio;
    } t_stats;

    typedef struct packed {
        logic        start;
        logic [15:0] prio;
        logic [15:0] count;
        logic [31:0] age;
    } t_score_req;

    localparam logic [15:0] PRIO_ONE  = 16'd256;
    localparam int unsigned SCORE_W   = 25;
    // recency term: 0.3 * 65536 * 1000 / (1000 + age)
    localparam logic [24:0] DIVIDEND  = 25'd19660800;
    localparam logic [32:0] REC_BASE  = 33'd1000;
    localparam int unsigned REC_Q_W   = 15;
    localparam logic [9:0]  DIV_HI    = DIVIDEND[24:15];
    localparam logic [14:0] DIV_LO    = DIVIDEND[14:0];
    // x / 5 as (x * M5) >> 28, exact for x below 2^26
    localparam logic [25:0] M5        = 26'd53687092;
    // x / 125 as (x * M125) >> 36, exact for x below 2^32
    localparam logic [29:0] M125      = 30'd549755814;

endpackage
`default_nettype wire

// ===== rtl/wlce_ram.sv =====
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module wlce_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/wlce_score.sv =====
// Eviction score unit: priority and count terms plus a serial recency divide
`timescale 1ns / 1ps
`default_nettype none
module wlce_score (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire wlce_pkg::t_score_req           i_req,
    output logic                                o_done,
    output logic [wlce_pkg::SCORE_W-1:0]        o_score
);

    logic        r_busy;
    logic [3:0]  r_step;
    logic [25:0] r_xp;
    logic [15:0] r_xc;
    logic [32:0] r_div;
    logic [33:0] r_rem;
    logic [14:0] r_low;
    logic [14:0] r_quo;
    logic [23:0] r_pterm;
    logic [22:0] r_cterm;
    logic        r_done;
    logic [wlce_pkg::SCORE_W-1:0] r_score;

    logic [51:0] w_pprod;
    logic [58:0] w_cprod;
    logic [33:0] w_trial;
    logic        w_ge;

    assign w_pprod = 52'(r_xp) * 52'(wlce_pkg::M5);
    assign w_cprod = 59'({r_xc, 13'd0}) * 59'(wlce_pkg::M125);
    // partial remainder stays below the divisor, so bit 33 is always clear
    assign w_trial = {r_rem[32:0], r_low[14]};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == 4'(wlce_pkg::REC_Q_W)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_xp  <= ({10'd0, i_req.prio} << 9) + ({10'd0, i_req.prio} << 8);
            r_xc  <= i_req.count;
            r_div <= {1'b0, i_req.age} + wlce_pkg::REC_BASE;
            r_rem <= 34'(wlce_pkg::DIV_HI);
            r_low <= wlce_pkg::DIV_LO;
            r_quo <= '0;
        end else if (r_busy) begin
            r_pterm <= w_pprod[51:28];
            r_cterm <= w_cprod[58:36];
            if (r_step == 4'(wlce_pkg::REC_Q_W)) begin
                r_score <= 25'(r_pterm) + 25'(r_cterm) + 25'(r_quo);
            end else begin
                r_low <= {r_low[13:0], 1'b0};
                if (w_ge) begin
                    r_rem <= w_trial - {1'b0, r_div};
                    r_quo <= {r_quo[13:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[13:0], 1'b0};
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_score = r_score;

endmodule
`default_nettype wire

// ===== rtl/weighted_layer_cache_eviction.sv =====
// Top level: byte-budgeted layer cache with weighted eviction
//
// Input channel (i_in_valid / o_in_ready) takes one command beat; the output
// channel (o_out_valid / i_out_ready) returns exactly one result beat per
// command. Configuration is a plain write port (i_cfg_we, i_cfg_index,
// i_cfg_data); it must be written only while the block is idle, which the
// block itself does not enforce. After reset a clearing pass over all
// MAX_ENTRIES entries initialises the statistics memory; o_in_ready stays low
// meanwhile. Layer sizes are not cleared. Bad indexes, unknown commands, an
// empty-table prefetch and reset priorities with no valid entries go from
// accept straight to the finish state; define, release, set priority and hits
// pass through the execute state first. Reset priorities does a read and a
// write per valid entry (read-modify-write). A miss that does not fit runs
// eviction passes: each pass reads every valid entry, a cached one also
// through the 15-step serial recency divider in the score unit; each pass
// ends with the end check, the victim read, the write-back and the fit check.
// One command is in flight at a time. A result waits in the output register
// while the next command is accepted; a stalled receiver holds the block
// only when the next result is ready to be written.
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_layer_cache_eviction_assert.svh"
module weighted_layer_cache_eviction #(
    parameter int unsigned MAX_ENTRIES = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [7:0]  i_layer_index,
    input  wire logic [31:0] i_layer_bytes,
    input  wire logic [15:0] i_new_priority,
    input  wire logic [31:0] i_now_ms,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic [8:0]       o_evicted_count,
    output logic [31:0]      o_cache_used,
    output logic [7:0]       o_served_layer
);

    localparam int unsigned AW = $clog2(MAX_ENTRIES);
    localparam logic [8:0] LIM_CAP = 9'((MAX_ENTRIES > 511) ? 511 : MAX_ENTRIES);
    localparam int unsigned STW = $bits(wlce_pkg::t_stats);

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_EXEC   = 12'b000000000100,
        S_RP_RD  = 12'b000000001000,
        S_RP_WR  = 12'b000000010000,
        S_LCHK   = 12'b000000100000,
        S_SC_RD  = 12'b000001000000,
        S_SC_WT  = 12'b000010000000,
        S_SC_SC  = 12'b000100000000,
        S_SC_END = 12'b001000000000,
        S_EV_WT  = 12'b010000000000,
        S_FIN    = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [8:0]  r_scan, n_scan;
    logic [8:0]  r_tgt, n_tgt;
    wlce_pkg::t_cmd r_cmd, n_cmd;
    logic [31:0] r_lbytes, n_lbytes;
    logic [15:0] r_nprio, n_nprio;
    logic [31:0] r_need, n_need;
    wlce_pkg::t_stats r_tstat, n_tstat;
    logic        r_found, n_found;
    logic [wlce_pkg::SCORE_W-1:0] r_best, n_best;
    logic [8:0]  r_worst, n_worst;
    logic [8:0]  r_evicted, n_evicted;
    wlce_pkg::t_status r_status, n_status;
    logic [7:0]  r_served, n_served;
    logic [31:0] r_bytes, n_bytes;
    logic [31:0] r_time, n_time;
    logic [8:0]  r_pref, n_pref;
    logic [31:0] r_max;
    logic [8:0]  r_liu;
    logic        r_out_valid, n_out_valid;
    wlce_pkg::t_status r_out_status;
    logic [8:0]  r_out_evicted;
    logic [31:0] r_out_used;
    logic [7:0]  r_out_served;
    logic        w_out_load;

    logic [8:0]  w_lim;
    logic        w_valid;
    logic [8:0]  w_pf;
    logic [8:0]  w_tgt_in;
    logic        w_fits;
    logic [AW-1:0] w_raddr;
    logic        w_st_we, w_sz_we;
    logic [AW-1:0] w_st_waddr;
    wlce_pkg::t_stats w_st_wdata, w_st_rdata;
    logic [31:0] w_sz_rdata;
    wlce_pkg::t_score_req w_sc_req;
    logic        w_sc_done;
    logic [wlce_pkg::SCORE_W-1:0] w_sc_score;

    function automatic wlce_pkg::t_stats touch(wlce_pkg::t_stats s, logic [31:0] t);
        wlce_pkg::t_stats v;
        v       = s;
        v.last  = t;
        v.count = (s.count == 16'hFFFF) ? s.count : s.count + 16'd1;
        return v;
    endfunction

    function automatic logic [31:0] sub_sat(logic [31:0] a, logic [31:0] b);
        return (a >= b) ? a - b : 32'd0;
    endfunction

    assign w_lim    = (r_liu < LIM_CAP) ? r_liu : LIM_CAP;
    assign w_valid  = ({1'b0, i_layer_index} < w_lim);
    assign w_pf     = (r_pref >= w_lim) ? 9'd0 : r_pref;
    assign w_tgt_in = (i_cmd == wlce_pkg::CMD_PREFETCH) ? w_pf : {1'b0, i_layer_index};
    assign w_fits   = ({1'b0, r_bytes} + {1'b0, r_need}) <= {1'b0, r_max};

    always_comb begin
        unique case (r_state)
            S_IDLE:   w_raddr = AW'(w_tgt_in);
            S_SC_RD,
            S_RP_RD:  w_raddr = AW'(r_scan);
            S_SC_END: w_raddr = AW'(r_worst);
            default:  w_raddr = AW'(r_tgt);
        endcase
    end

    wlce_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (w_sz_we),
        .i_waddr (AW'(r_tgt)),
        .i_wdata (r_lbytes),
        .i_raddr (w_raddr),
        .o_rdata (w_sz_rdata)
    );

    wlce_ram #(.WIDTH(STW), .DEPTH(MAX_ENTRIES)) u_stats_ram (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_st_waddr),
        .i_wdata (w_st_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_st_rdata)
    );

    wlce_score u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_sc_req),
        .o_done  (w_sc_done),
        .o_score (w_sc_score)
    );

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_scan      = r_scan;
        n_tgt       = r_tgt;
        n_cmd       = r_cmd;
        n_lbytes    = r_lbytes;
        n_nprio     = r_nprio;
        n_need      = r_need;
        n_tstat     = r_tstat;
        n_found     = r_found;
        n_best      = r_best;
        n_worst     = r_worst;
        n_evicted   = r_evicted;
        n_status    = r_status;
        n_served    = r_served;
        n_bytes     = r_bytes;
        n_time      = r_time;
        n_pref      = r_pref;
        o_in_ready  = 1'b0;
        w_out_load  = 1'b0;
        w_st_we     = 1'b0;
        w_sz_we     = 1'b0;
        w_st_waddr  = AW'(r_tgt);
        w_st_wdata  = w_st_rdata;
        w_sc_req.start = 1'b0;
        w_sc_req.prio  = w_st_rdata.prio;
        w_sc_req.count = w_st_rdata.count;
        w_sc_req.age   = r_time - w_st_rdata.last;

        unique case (r_state)
            S_CLEAR: begin
                w_st_we    = 1'b1;
                w_st_waddr = r_clr;
                w_st_wdata = '{cached: 1'b0, last: 32'd0, count: 16'd0,
                               prio: wlce_pkg::PRIO_ONE};
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(MAX_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cmd     = wlce_pkg::t_cmd'(i_cmd);
                    n_lbytes  = i_layer_bytes;
                    n_nprio   = i_new_priority;
                    n_evicted = 9'd0;
                    n_served  = i_layer_index;
                    n_status  = wlce_pkg::ST_DONE;
                    n_tgt     = {1'b0, i_layer_index};
                    n_state   = S_FIN;
                    unique case (wlce_pkg::t_cmd'(i_cmd))
                        wlce_pkg::CMD_DEFINE,
                        wlce_pkg::CMD_REQUEST,
                        wlce_pkg::CMD_RELEASE,
                        wlce_pkg::CMD_SETPRIO: begin
                            if (!w_valid) begin
                                n_status = wlce_pkg::ST_BAD_INDEX;
                            end else begin
                                n_state = S_EXEC;
                                if (i_cmd == wlce_pkg::CMD_REQUEST) begin
                                    n_time = i_now_ms;
                                end
                            end
                        end
                        wlce_pkg::CMD_RSTPRIO: begin
                            n_scan = 9'd0;
                            if (w_lim != 9'd0) begin
                                n_state = S_RP_RD;
                            end
                        end
                        wlce_pkg::CMD_PREFETCH: begin
                            if (w_lim == 9'd0) begin
                                n_status = wlce_pkg::ST_BAD_INDEX;
                                n_served = 8'd0;
                            end else begin
                                n_tgt    = w_pf;
                                n_served = w_pf[7:0];
                                n_pref   = w_pf + 9'd1;
                                n_state  = S_EXEC;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
                unique case (r_cmd)
                    wlce_pkg::CMD_DEFINE: begin
                        if (w_st_rdata.cached) begin
                            n_bytes = sub_sat(r_bytes, w_sz_rdata);
                        end
                        w_sz_we    = 1'b1;
                        w_st_we    = 1'b1;
                        w_st_wdata = '{cached: 1'b0, last: 32'd0, count: 16'd0,
                                       prio: wlce_pkg::PRIO_ONE};
                    end
                    wlce_pkg::CMD_REQUEST,
                    wlce_pkg::CMD_PREFETCH: begin
                        if (w_st_rdata.cached) begin
                            n_status = wlce_pkg::ST_HIT;
                            if (r_cmd == wlce_pkg::CMD_REQUEST) begin
                                w_st_we    = 1'b1;
                                w_st_wdata = touch(w_st_rdata, r_time);
                            end
                        end else begin
                            n_need  = w_sz_rdata;
                            n_tstat = w_st_rdata;
                            n_state = S_LCHK;
                        end
                    end
                    wlce_pkg::CMD_RELEASE: begin
                        if (w_st_rdata.cached) begin
                            n_bytes           = sub_sat(r_bytes, w_sz_rdata);
                            w_st_we           = 1'b1;
                            w_st_wdata.cached = 1'b0;
                        end
                    end
                    wlce_pkg::CMD_SETPRIO: begin
                        w_st_we         = 1'b1;
                        w_st_wdata.prio = r_nprio;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_RP_RD: begin
                n_state = S_RP_WR;
            end
            S_RP_WR: begin
                w_st_we         = 1'b1;
                w_st_waddr      = AW'(r_scan);
                w_st_wdata.prio = wlce_pkg::PRIO_ONE;
                n_scan          = r_scan + 9'd1;
                n_state         = (r_scan + 9'd1 == w_lim) ? S_FIN : S_RP_RD;
            end
            S_LCHK: begin
                if (w_fits) begin
                    n_bytes           = r_bytes + r_need;
                    w_st_we           = 1'b1;
                    w_st_wdata        = touch(r_tstat, r_time);
                    w_st_wdata.cached = 1'b1;
                    n_status          = wlce_pkg::ST_LOADED;
                    n_state           = S_FIN;
                end else begin
                    n_scan  = 9'd0;
                    n_found = 1'b0;
                    n_state = S_SC_RD;
                end
            end
            S_SC_RD: begin
                n_state = (r_scan == w_lim) ? S_SC_END : S_SC_WT;
            end
            S_SC_WT: begin
                if (w_st_rdata.cached) begin
                    w_sc_req.start = 1'b1;
                    n_state        = S_SC_SC;
                end else begin
                    n_scan  = r_scan + 9'd1;
                    n_state = S_SC_RD;
                end
            end
            S_SC_SC: begin
                if (w_sc_done) begin
                    // strict compare keeps the lowest index on ties
                    if (!r_found || (w_sc_score < r_best)) begin
                        n_found = 1'b1;
                        n_best  = w_sc_score;
                        n_worst = r_scan;
                    end
                    n_scan  = r_scan + 9'd1;
                    n_state = S_SC_RD;
                end
            end
            S_SC_END: begin
                if (!r_found) begin
                    n_status = wlce_pkg::ST_NO_SPACE;
                    n_state  = S_FIN;
                end else begin
                    n_state = S_EV_WT;
                end
            end
            S_EV_WT: begin
                w_st_we           = 1'b1;
                w_st_waddr        = AW'(r_worst);
                w_st_wdata.cached = 1'b0;
                n_bytes           = sub_sat(r_bytes, w_sz_rdata);
                n_evicted         = r_evicted + 9'd1;
                n_state           = S_LCHK;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = w_out_load ? 1'b1 : (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_bytes     <= 32'd0;
            r_time      <= 32'd0;
            r_pref      <= 9'd0;
            r_found     <= 1'b0;
            r_evicted   <= 9'd0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_bytes     <= n_bytes;
            r_time      <= n_time;
            r_pref      <= n_pref;
            r_found     <= n_found;
            r_evicted   <= n_evicted;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan   <= n_scan;
        r_tgt    <= n_tgt;
        r_cmd    <= n_cmd;
        r_lbytes <= n_lbytes;
        r_nprio  <= n_nprio;
        r_need   <= n_need;
        r_tstat  <= n_tstat;
        r_best   <= n_best;
        r_worst  <= n_worst;
        r_status <= n_status;
        r_served <= n_served;
        if (w_out_load) begin
            r_out_status  <= r_status;
            r_out_evicted <= r_evicted;
            r_out_used    <= r_bytes;
            r_out_served  <= r_served;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= 32'd268435456;
            r_liu <= 9'd0;
        end else if (i_cfg_we) begin
            if (i_cfg_index) begin
                r_liu <= i_cfg_data[8:0];
            end else begin
                r_max <= i_cfg_data;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_evicted_count = r_out_evicted;
    assign o_cache_used    = r_out_used;
    assign o_served_layer  = r_out_served;

    // the count of the last command may exceed a table shrunk while idle
    `WLCE_ASSERT_IMPL(a_evict_bound, i_clk, i_rst_n, (r_state != S_CLEAR && r_state != S_IDLE), (r_evicted <= w_lim))
    `WLCE_ASSERT_NEXT(a_load_fits, i_clk, i_rst_n, (r_state == S_LCHK && w_fits), (r_bytes <= r_max))
    `WLCE_ASSERT_IMPL(a_worst_range, i_clk, i_rst_n, (r_state == S_SC_END && r_found), (r_worst < w_lim))
    `WLCE_ASSERT_NEXT(a_fin_hold, i_clk, i_rst_n, (r_state == S_FIN && r_out_valid && !i_out_ready), (r_state == S_FIN))

endmodule
`default_nettype wire
